[sv/btok_pkg.sv]
// Shared types and constants for the byte stream tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package btok_pkg;

   // Lexer modes, one-hot
   typedef enum logic [12:0] {
      M_IDLE   = 13'b0000000000001,
      M_IDENT  = 13'b0000000000010,
      M_NUMBER = 13'b0000000000100,
      M_SLASH  = 13'b0000000001000,
      M_DASH   = 13'b0000000010000,
      M_QOPEN  = 13'b0000000100000,
      M_QUOTED = 13'b0000001000000,
      M_QESC   = 13'b0000010000000,
      M_RAW    = 13'b0000100000000,
      M_LINE   = 13'b0001000000000,
      M_BLOCK  = 13'b0010000000000,
      M_BSTAR  = 13'b0100000000000,
      M_HALT   = 13'b1000000000000
   } mode_type;

   // Record types
   localparam logic [1:0] REC_TOKEN   = 2'd0;
   localparam logic [1:0] REC_COMMENT = 2'd1;
   localparam logic [1:0] REC_MARK    = 2'd2;
   localparam logic [1:0] REC_DIAG    = 2'd3;

   // Token kinds; records that are not tokens carry KIND_NONE
   localparam logic [3:0] KIND_NONE   = 4'd0;
   localparam logic [3:0] KIND_END    = 4'd0;
   localparam logic [3:0] KIND_IDENT  = 4'd1;
   localparam logic [3:0] KIND_NUMBER = 4'd2;
   localparam logic [3:0] KIND_STRING = 4'd3;
   localparam logic [3:0] KIND_LBRACE = 4'd4;
   localparam logic [3:0] KIND_RBRACE = 4'd5;
   localparam logic [3:0] KIND_LBRACK = 4'd6;
   localparam logic [3:0] KIND_RBRACK = 4'd7;
   localparam logic [3:0] KIND_COMMA  = 4'd8;
   localparam logic [3:0] KIND_EQUAL  = 4'd9;
   localparam logic [3:0] KIND_AT     = 4'd10;
   localparam logic [3:0] KIND_COLON  = 4'd11;
   localparam logic [3:0] KIND_SLASH  = 4'd12;
   localparam logic [3:0] KIND_STAR   = 4'd13;
   localparam logic [3:0] KIND_ARROW  = 4'd14;

   // Diagnostic codes; records that are not diagnostics carry DIAG_NONE
   localparam logic [2:0] DIAG_NONE      = 3'd0;
   localparam logic [2:0] DIAG_NEWLINE   = 3'd0;
   localparam logic [2:0] DIAG_UNTERM    = 3'd1;
   localparam logic [2:0] DIAG_UNTERM_RAW = 3'd2;
   localparam logic [2:0] DIAG_BLOCK     = 3'd3;
   localparam logic [2:0] DIAG_ARROW     = 3'd4;
   localparam logic [2:0] DIAG_STRAY     = 3'd5;
   localparam logic [2:0] DIAG_TOO_LARGE = 3'd6;

   // Input op codes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_END  = 1'b1;

   // Characters
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   // Result queue sizing: room for three records per beat plus slack
   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = RSP_PTR_W + 1;
   localparam int MAX_RECS  = 3;

   // One result record, without the last-of-run mark
   typedef struct packed {
      logic [1:0]  record_type;
      logic [3:0]  token_kind;
      logic [31:0] span_offset;
      logic [31:0] span_length;
      logic        line_code;
      logic [31:0] comment_number;
      logic [2:0]  diag_code;
      logic        all_ok;
   } rec_type;

   // Records produced by one input beat
   typedef struct packed {
      logic [1:0]  n;
      rec_type [MAX_RECS-1:0] recs;
   } push_type;

endpackage

`default_nettype wire

[sv/btok_lexer.sv]
// Lexer state and single-beat step logic producing up to three records.
`timescale 1ns / 1ps
`default_nettype none

module btok_lexer import btok_pkg::*; #(
   parameter int OFFSET_WIDTH = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step_valid,
   input  wire logic       step_op,
   input  wire logic [7:0] step_byte,
   output push_type        push
);

   localparam int W = OFFSET_WIDTH;
   localparam logic [W-1:0] POS_ONE = W'(1);
   localparam logic [W-1:0] POS_TWO = W'(2);
   localparam logic [W-1:0] POS_MAX = {W{1'b1}};

   typedef struct packed {
      mode_type    mode;
      logic [W-1:0] byte_position;
      logic [W-1:0] token_start;
      logic        line_has_code;
      logic        comment_open;
      logic [31:0] open_comment_number;
      logic [1:0]  newline_count;
      logic [31:0] comment_count;
      logic        doc_ok;
      logic [1:0]  quote_run;
      logic        overflow;
   } state_type;

   typedef struct packed {
      state_type st;
      push_type  out;
   } work_type;

   state_type st_ff;
   state_type st_in;
   work_type  work;

   function automatic state_type reset_state();
      state_type s;
      s = '0;
      s.mode   = M_IDLE;
      s.doc_ok = 1'b1;
      return s;
   endfunction

   function automatic logic [31:0] to32(input logic [W-1:0] x);
      logic [63:0] wide;
      wide = 64'(x);
      return wide[31:0];
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) || b == CH_UNDER;
   endfunction

   function automatic logic is_num_char(input logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

   function automatic logic is_blank(input logic [7:0] b);
      return b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF;
   endfunction

   function automatic logic [3:0] punct_code(input logic [7:0] b);
      logic [3:0] k;
      case (b)
         CH_LBRACE: k = KIND_LBRACE;
         CH_RBRACE: k = KIND_RBRACE;
         CH_LBRACK: k = KIND_LBRACK;
         CH_RBRACK: k = KIND_RBRACK;
         CH_COMMA:  k = KIND_COMMA;
         CH_EQUAL:  k = KIND_EQUAL;
         CH_AT:     k = KIND_AT;
         CH_COLON:  k = KIND_COLON;
         CH_STAR:   k = KIND_STAR;
         default:   k = KIND_NONE;
      endcase
      return k;
   endfunction

   // Append one record, stamped with the current ok flag
   function automatic work_type put(input work_type w, input logic [1:0] rt,
                                    input logic [3:0] kind, input logic [31:0] off,
                                    input logic [31:0] len, input logic cb,
                                    input logic [31:0] num, input logic [2:0] dc);
      rec_type r;
      r.record_type    = rt;
      r.token_kind     = kind;
      r.span_offset    = off;
      r.span_length    = len;
      r.line_code      = cb;
      r.comment_number = num;
      r.diag_code      = dc;
      r.all_ok         = w.st.doc_ok;
      if (w.out.n != 2'd3) begin
         w.out.recs[w.out.n] = r;
         w.out.n = w.out.n + 2'd1;
      end
      return w;
   endfunction

   function automatic work_type tok(input work_type w, input logic [3:0] kind,
                                    input logic [W-1:0] off, input logic [W-1:0] len);
      return put(w, REC_TOKEN, kind, to32(off), to32(len), 1'b0, 32'd0, DIAG_NONE);
   endfunction

   function automatic work_type diag(input work_type w, input logic [2:0] code,
                                     input logic [W-1:0] off, input logic [W-1:0] len);
      work_type v;
      v = w;
      v.st.doc_ok = 1'b0;
      return put(v, REC_DIAG, KIND_NONE, to32(off), to32(len), 1'b0, 32'd0, code);
   endfunction

   function automatic work_type mark(input work_type w);
      return put(w, REC_MARK, KIND_NONE, 32'd0, 32'd0, 1'b0, w.st.open_comment_number,
                 DIAG_NONE);
   endfunction

   // Byte arriving with no token pending
   function automatic work_type start_byte(input work_type w, input logic [7:0] b,
                                           input logic [W-1:0] pos);
      work_type   v;
      logic [3:0] k;
      v = w;
      k = punct_code(b);
      v.st.mode = M_IDLE;
      if (b == CH_LF) begin
         v.st.line_has_code = 1'b0;
         if (v.st.comment_open) begin
            if (v.st.newline_count < 2'd2) begin
               v.st.newline_count = v.st.newline_count + 2'd1;
            end
            if (v.st.newline_count >= 2'd2) begin
               v = mark(v);
               v.st.comment_open = 1'b0;
            end
         end
      end else if (!is_blank(b)) begin
         v.st.token_start = pos;
         if (b == CH_SLASH) begin
            v.st.mode = M_SLASH;
         end else begin
            v.st.comment_open = 1'b0;
            v.st.line_has_code = 1'b1;
            if (is_alpha(b)) begin
               v.st.mode = M_IDENT;
            end else if (is_num_char(b)) begin
               v.st.mode = M_NUMBER;
            end else if (b == CH_QUOTE) begin
               v.st.mode = M_QOPEN;
               v.st.quote_run = 2'd1;
            end else if (b == CH_DASH) begin
               v.st.mode = M_DASH;
            end else if (k != KIND_NONE) begin
               v = tok(v, k, pos, POS_ONE);
            end else begin
               v = diag(v, DIAG_STRAY, pos, POS_ONE);
            end
         end
      end
      return v;
   endfunction

   // Byte inside a plain quoted string
   function automatic work_type quoted_byte(input work_type w, input logic [7:0] b,
                                            input logic [W-1:0] pos);
      work_type v;
      v = w;
      v.st.mode = M_QUOTED;
      if (b == CH_LF) begin
         v = diag(v, DIAG_NEWLINE, v.st.token_start, POS_ONE);
         v.st.mode = M_HALT;
      end else if (b == CH_BSLASH) begin
         v.st.mode = M_QESC;
      end else if (b == CH_QUOTE) begin
         v = tok(v, KIND_STRING, v.st.token_start, pos - v.st.token_start + POS_ONE);
         v.st.mode = M_IDLE;
      end
      return v;
   endfunction

   function automatic work_type lex_byte(input work_type w, input logic [7:0] b,
                                         input logic [W-1:0] pos);
      work_type     v;
      logic [W-1:0] ts;
      v = w;
      ts = w.st.token_start;
      case (w.st.mode)
         M_IDENT: begin
            if (!(is_alpha(b) || is_num_char(b))) begin
               v = tok(v, KIND_IDENT, ts, pos - ts);
               v = start_byte(v, b, pos);
            end
         end
         M_NUMBER: begin
            if (!is_num_char(b)) begin
               v = tok(v, KIND_NUMBER, ts, pos - ts);
               v = start_byte(v, b, pos);
            end
         end
         M_SLASH: begin
            if (b == CH_SLASH) begin
               v.st.mode = M_LINE;
               v.st.comment_open = 1'b1;
               v.st.open_comment_number = v.st.comment_count;
               v.st.comment_count = v.st.comment_count + 32'd1;
               v.st.newline_count = 2'd0;
            end else if (b == CH_STAR) begin
               v = diag(v, DIAG_BLOCK, ts, POS_TWO);
               v.st.mode = M_BLOCK;
            end else begin
               v.st.comment_open = 1'b0;
               v.st.line_has_code = 1'b1;
               v = tok(v, KIND_SLASH, ts, POS_ONE);
               v = start_byte(v, b, pos);
            end
         end
         M_DASH: begin
            if (b == CH_GT) begin
               v = tok(v, KIND_ARROW, ts, POS_TWO);
               v.st.mode = M_IDLE;
            end else begin
               v = diag(v, DIAG_ARROW, ts, POS_ONE);
               v = start_byte(v, b, pos);
            end
         end
         M_QOPEN: begin
            if (v.st.quote_run == 2'd1) begin
               if (b == CH_QUOTE) begin
                  v.st.quote_run = 2'd2;
               end else begin
                  v = quoted_byte(v, b, pos);
               end
            end else begin
               v.st.quote_run = 2'd0;
               if (b == CH_QUOTE) begin
                  v.st.mode = M_RAW;
               end else begin
                  // empty quoted string
                  v = tok(v, KIND_STRING, ts, POS_TWO);
                  v = start_byte(v, b, pos);
               end
            end
         end
         M_QUOTED: v = quoted_byte(v, b, pos);
         M_QESC:   v.st.mode = M_QUOTED;
         M_RAW: begin
            if (b != CH_QUOTE) begin
               v.st.quote_run = 2'd0;
            end else begin
               v.st.quote_run = v.st.quote_run + 2'd1;
               if (v.st.quote_run == 2'd3) begin
                  v.st.quote_run = 2'd0;
                  v = tok(v, KIND_STRING, ts, pos - ts + POS_ONE);
                  v.st.mode = M_IDLE;
               end
            end
         end
         M_LINE: begin
            if (b == CH_LF) begin
               v = put(v, REC_COMMENT, KIND_NONE, to32(ts), to32(pos - ts),
                       v.st.line_has_code, v.st.open_comment_number, DIAG_NONE);
               v = start_byte(v, b, pos);
            end
         end
         M_BLOCK: begin
            if (b == CH_STAR) begin
               v.st.mode = M_BSTAR;
            end
         end
         M_BSTAR: begin
            if (b == CH_SLASH) begin
               v.st.mode = M_IDLE;
            end else if (b != CH_STAR) begin
               v.st.mode = M_BLOCK;
            end
         end
         M_HALT: v = w;
         default: v = start_byte(v, b, pos);
      endcase
      return v;
   endfunction

   // Flush what is pending at the end item, mark a comment still open, then emit End
   function automatic work_type finish(input work_type w);
      work_type     v;
      logic [W-1:0] pos;
      logic [W-1:0] ts;
      v = w;
      pos = w.st.byte_position;
      ts = w.st.token_start;
      case (w.st.mode)
         M_IDENT:  v = tok(v, KIND_IDENT, ts, pos - ts);
         M_NUMBER: v = tok(v, KIND_NUMBER, ts, pos - ts);
         M_SLASH: begin
            v.st.comment_open = 1'b0;
            v.st.line_has_code = 1'b1;
            v = tok(v, KIND_SLASH, ts, POS_ONE);
         end
         M_DASH: v = diag(v, DIAG_ARROW, ts, POS_ONE);
         M_QOPEN: begin
            if (v.st.quote_run == 2'd2) begin
               v = tok(v, KIND_STRING, ts, POS_TWO);
            end else begin
               v = diag(v, DIAG_UNTERM, ts, POS_ONE);
            end
         end
         M_QUOTED: v = diag(v, DIAG_UNTERM, ts, POS_ONE);
         M_QESC:   v = diag(v, DIAG_UNTERM, ts, POS_ONE);
         M_RAW:    v = diag(v, DIAG_UNTERM_RAW, ts, POS_ONE);
         M_LINE: begin
            v = put(v, REC_COMMENT, KIND_NONE, to32(ts), to32(pos - ts),
                    v.st.line_has_code, v.st.open_comment_number, DIAG_NONE);
         end
         default: v = w;
      endcase
      if (v.st.comment_open) begin
         v = mark(v);
      end
      v = tok(v, KIND_END, pos, '0);
      return v;
   endfunction

   // Step the lexer on the registered beat
   always_comb begin
      work.st  = st_ff;
      work.out = '0;
      if (step_valid) begin
         if (step_op == OP_END) begin
            work = finish(work);
            work.st = reset_state();
         end else if (!st_ff.overflow) begin
            if (st_ff.byte_position == POS_MAX) begin
               work.st.overflow = 1'b1;
               work.st.comment_open = 1'b0;
               work.st.mode = M_HALT;
               work = diag(work, DIAG_TOO_LARGE, '0, '0);
            end else begin
               work = lex_byte(work, step_byte, st_ff.byte_position);
               work.st.byte_position = st_ff.byte_position + POS_ONE;
            end
         end
      end
      st_in = work.st;
      push  = work.out;
   end

   // Hold lexer state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= reset_state();
      end else begin
         st_ff <= st_in;
      end
   end

endmodule

`default_nettype wire

[sv/btok_rsp_fifo.sv]
// Result record queue: takes up to three records per beat, drains one per beat.
`timescale 1ns / 1ps
`default_nettype none

module btok_rsp_fifo import btok_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  push_type  push,
   output logic      room,
   output logic      out_valid,
   input  wire logic out_ready,
   output rec_type   out_rec,
   output logic      out_last
);

   typedef struct packed {
      rec_type rec;
      logic    last;
   } entry_type;

   entry_type              entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic                   pop;

   // Handshake and occupancy
   assign out_valid = (count_ff != '0);
   assign pop       = out_valid && out_ready;
   assign room      = (count_ff <= RSP_CNT_W'(RSP_DEPTH - MAX_RECS));
   assign out_rec   = entry_ff[rd_ptr_ff].rec;
   assign out_last  = entry_ff[rd_ptr_ff].last;

   assign wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.n);
   assign rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
   assign count_in  = count_ff + RSP_CNT_W'(push.n) - RSP_CNT_W'(pop);

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store records; mark the last one of the beat
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RECS; i++) begin
         if (2'(i) < push.n) begin
            entry_ff[wr_ptr_ff + RSP_PTR_W'(i)] <= '{rec: push.recs[i],
                                                     last: (2'(i) == push.n - 2'd1)};
         end
      end
   end

endmodule

`default_nettype wire

[sv/byte_stream_tokenizer_core.sv]
// Top level of the byte stream tokenizer: input register, lexer, result queue.
//
// Usage:
//   req channel: one beat per document byte (req_tuser = 0, byte in req_tdata),
//   then one end-of-document beat (req_tuser = 1) that flushes pending output,
//   emits the End token with the final ok flag and returns the lexer to its
//   initial state, ready for the next document.
//   rsp channel: token, comment, blank-after mark and diagnostic records, one
//   per beat; rsp_tuser carries the record type, rsp_tlast marks the last
//   record caused by one request beat. A byte may cause zero to three records.
//   A byte is registered at acceptance, lexed into the result queue once the
//   queue has room for three records, and its records are then presented
//   from the queue registers.
//   Throughput: one request beat per cycle as long as the lexer emits at most
//   one record per byte on average; the 8-entry result queue absorbs bursts,
//   and a beat is taken by the lexer only with room for three records.
//   When the receiver stalls, the queue fills and req_tready falls; nothing
//   is dropped. Reset clears the lexer state and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module byte_stream_tokenizer_core import btok_pkg::*; #(
   parameter int OFFSET_WIDTH = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] byte_value
   input  wire logic [0:0]   req_tuser,   // [0] op
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [111:0]      rsp_tdata,   // [3:0] token_kind, [35:4] span_offset,
                                          // [67:36] span_length, [68] line_code,
                                          // [100:69] comment_number,
                                          // [103:101] diag_code, [104] all_ok, zero fill
   output logic [1:0]        rsp_tuser,   // [1:0] record_type
   output logic              rsp_tlast
);

   logic       in_valid_ff, in_valid_in;
   logic       in_op_ff;
   logic [7:0] in_byte_ff;
   logic       room;
   logic       step_fire;
   logic       req_fire;
   push_type   push;
   rec_type    out_rec;

   // Take a beat into the input register whenever it is empty or empties this cycle
   assign step_fire   = in_valid_ff && room;
   assign req_tready  = !in_valid_ff || step_fire;
   assign req_fire    = req_tvalid && req_tready;
   assign in_valid_in = req_fire || (in_valid_ff && !step_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Hold the payload of the registered beat
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_op_ff   <= req_tuser[0];
         in_byte_ff <= req_tdata;
      end
   end

   btok_lexer #(
      .OFFSET_WIDTH(OFFSET_WIDTH)
   ) u_lexer (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step_fire),
      .step_op    (in_op_ff),
      .step_byte  (in_byte_ff),
      .push       (push)
   );

   btok_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rec   (out_rec),
      .out_last  (rsp_tlast)
   );

   // Pack the result beat
   assign rsp_tdata = {7'd0, out_rec.all_ok, out_rec.diag_code, out_rec.comment_number,
                       out_rec.line_code, out_rec.span_length, out_rec.span_offset,
                       out_rec.token_kind};
   assign rsp_tuser = out_rec.record_type;

endmodule

`default_nettype wire
